// ----- hdl/ita_pkg.sv -----
// Shared constants and character helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps
package ita_pkg;

  // Conversion kind codes; only the hex bit is decoded for the radix.
  localparam logic [1:0] KIND_SDEC    = 2'd0;
  localparam logic [1:0] KIND_UDEC    = 2'd1;
  localparam logic [1:0] KIND_HEX     = 2'd2;
  localparam int         KIND_HEX_BIT = 1;

  // Binary bits shifted into the BCD register per pipeline stage
  localparam int DABBLE_STEPS = 4;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // ASCII character of one digit (decimal digits never exceed nine)
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return HEX_DIGITS[d];
  endfunction

endpackage

// ----- hdl/ita_if.sv -----
// Valid/ready channel interfaces for numbers in and characters out.
`timescale 1ns / 1ps
interface ita_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface ita_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;
  logic [3:0] char_count;

  modport source (output valid, char_out, last, char_count, input ready);
  modport sink   (input valid, char_out, last, char_count, output ready);
endinterface

// ----- hdl/integer_to_ascii_formatter_core.sv -----
// Top level of the integer to ASCII formatter.
`timescale 1ns / 1ps
// Converts each VALUE_BITS-wide number on din into ASCII characters on dout,
// most significant first: signed decimal (kind 0), unsigned decimal (kind 1)
// or lowercase hex (kind 2 and 3), no leading zeros, zero as a single '0',
// '-' before negative signed values. The word carrying the final character
// has last set and char_count holding the character count (low four bits).
// Conversion runs in a pipeline of one decode stage, ceil(VALUE_BITS/4)
// binary to BCD stages and one digit count stage, then a serializer that
// sends a number's characters one word at a time and takes the next number
// as the last word of the one before is taken. A number has 1 to 11
// characters at 32 bits; the pipeline in front of the serializer buffers
// up to ceil(VALUE_BITS/4) + 2 more numbers. The block keeps no state
// between numbers.
module integer_to_ascii_formatter_core
  import ita_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  ita_in_if.sink    din,
  ita_out_if.source dout
);

  localparam int NDIG = (VALUE_BITS * 302) / 1000 + 1;
  localparam int NST  = (VALUE_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS;
  localparam int NDW  = $clog2(NDIG + 2);

  logic [NST:0]                 st_valid;
  logic [NST:0]                 st_ready;
  logic [NST:0]                 st_hex;
  logic [NST:0]                 st_neg;
  logic [NST:0][VALUE_BITS-1:0] st_mag;
  logic [NST:0][4*NDIG-1:0]     st_bcd;
  logic [NST:0][VALUE_BITS-1:0] st_shf;

  logic              cnt_valid;
  logic              cnt_ready;
  logic              cnt_neg;
  logic [4*NDIG-1:0] cnt_digs;
  logic [NDW-1:0]    cnt_nd;

  ita_prep #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .kind     (din.kind),
    .value    (din.value),
    .out_valid(st_valid[0]),
    .out_ready(st_ready[0]),
    .out_hex  (st_hex[0]),
    .out_neg  (st_neg[0]),
    .out_mag  (st_mag[0]),
    .out_bcd  (st_bcd[0]),
    .out_shf  (st_shf[0])
  );

  // Binary to BCD, DABBLE_STEPS bits per stage; the last stage takes the rest
  for (genvar i = 0; i < NST; i++) begin : g_dabble
    localparam int REM   = VALUE_BITS - DABBLE_STEPS * i;
    localparam int STEPS = (REM < DABBLE_STEPS) ? REM : DABBLE_STEPS;

    ita_dabble #(
      .VALUE_BITS(VALUE_BITS),
      .NDIG      (NDIG),
      .STEPS     (STEPS)
    ) u_dabble (
      .clk      (clk),
      .rst      (rst),
      .in_valid (st_valid[i]),
      .in_ready (st_ready[i]),
      .in_hex   (st_hex[i]),
      .in_neg   (st_neg[i]),
      .in_mag   (st_mag[i]),
      .in_bcd   (st_bcd[i]),
      .in_shf   (st_shf[i]),
      .out_valid(st_valid[i+1]),
      .out_ready(st_ready[i+1]),
      .out_hex  (st_hex[i+1]),
      .out_neg  (st_neg[i+1]),
      .out_mag  (st_mag[i+1]),
      .out_bcd  (st_bcd[i+1]),
      .out_shf  (st_shf[i+1])
    );
  end

  ita_count #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG),
    .NDW       (NDW)
  ) u_count (
    .clk      (clk),
    .rst      (rst),
    .in_valid (st_valid[NST]),
    .in_ready (st_ready[NST]),
    .in_hex   (st_hex[NST]),
    .in_neg   (st_neg[NST]),
    .in_mag   (st_mag[NST]),
    .in_bcd   (st_bcd[NST]),
    .out_valid(cnt_valid),
    .out_ready(cnt_ready),
    .out_neg  (cnt_neg),
    .out_digs (cnt_digs),
    .out_nd   (cnt_nd)
  );

  ita_emit #(
    .NDIG(NDIG),
    .NDW (NDW)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .in_valid(cnt_valid),
    .in_ready(cnt_ready),
    .in_neg  (cnt_neg),
    .in_digs (cnt_digs),
    .in_nd   (cnt_nd),
    .dout    (dout)
  );

endmodule

// ----- hdl/ita_prep.sv -----
// Input stage: decodes the kind and forms the unsigned magnitude.
`timescale 1ns / 1ps
module ita_prep
  import ita_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hex,
  output logic                  out_neg,
  output logic [VALUE_BITS-1:0] out_mag,
  output logic [4*NDIG-1:0]     out_bcd,
  output logic [VALUE_BITS-1:0] out_shf
);

  logic                  neg_next;
  logic [VALUE_BITS-1:0] mag_next;

  assign in_ready = !out_valid || out_ready;

  // Two's complement negate; the most negative value maps onto itself,
  // which read unsigned is the right magnitude.
  always_comb begin
    neg_next = (kind == KIND_SDEC) && value[VALUE_BITS-1];
    mag_next = neg_next ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_hex <= kind[KIND_HEX_BIT];
      out_neg <= neg_next;
      out_mag <= mag_next;
      out_bcd <= '0;
      out_shf <= mag_next;
    end
  end

endmodule

// ----- hdl/ita_dabble.sv -----
// One shift-and-add-3 stage of the pipelined binary to BCD converter.
`timescale 1ns / 1ps
module ita_dabble
  import ita_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10,
  parameter int STEPS      = DABBLE_STEPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_hex,
  input  logic                  in_neg,
  input  logic [VALUE_BITS-1:0] in_mag,
  input  logic [4*NDIG-1:0]     in_bcd,
  input  logic [VALUE_BITS-1:0] in_shf,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hex,
  output logic                  out_neg,
  output logic [VALUE_BITS-1:0] out_mag,
  output logic [4*NDIG-1:0]     out_bcd,
  output logic [VALUE_BITS-1:0] out_shf
);

  logic [4*NDIG-1:0]     bcd_next;
  logic [VALUE_BITS-1:0] shf_next;

  assign in_ready = !out_valid || out_ready;

  // Correct each digit of five or more, then shift the next binary bit in
  always_comb begin
    bcd_next = in_bcd;
    shf_next = in_shf;
    for (int st = 0; st < STEPS; st++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[4*NDIG-2:0], shf_next[VALUE_BITS-1]};
      shf_next = {shf_next[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_hex <= in_hex;
      out_neg <= in_neg;
      out_mag <= in_mag;
      out_bcd <= bcd_next;
      out_shf <= shf_next;
    end
  end

endmodule

// ----- hdl/ita_count.sv -----
// Digit select stage: picks hex nibbles or BCD digits and counts significant digits.
`timescale 1ns / 1ps
module ita_count
  import ita_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10,
  parameter int NDW        = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_hex,
  input  logic                  in_neg,
  input  logic [VALUE_BITS-1:0] in_mag,
  input  logic [4*NDIG-1:0]     in_bcd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_neg,
  output logic [4*NDIG-1:0]     out_digs,
  output logic [NDW-1:0]        out_nd
);

  logic [4*NDIG-1:0] digs_next;
  logic [NDW-1:0]    nd_next;

  assign in_ready = !out_valid || out_ready;

  // Highest nonzero digit sets the length; zero still gives one digit
  always_comb begin
    digs_next = in_hex ? {{(4*NDIG-VALUE_BITS){1'b0}}, in_mag} : in_bcd;
    nd_next   = NDW'(1);
    for (int d = 1; d < NDIG; d++) begin
      if (digs_next[4*d +: 4] != 4'd0) begin
        nd_next = NDW'(d + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_neg  <= in_neg;
      out_digs <= digs_next;
      out_nd   <= nd_next;
    end
  end

endmodule

// ----- hdl/ita_emit.sv -----
// Character serializer: sends the sign and then the digits, most significant first.
`timescale 1ns / 1ps
module ita_emit
  import ita_pkg::*;
#(
  parameter int NDIG = 10,
  parameter int NDW  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_neg,
  input  logic [4*NDIG-1:0] in_digs,
  input  logic [NDW-1:0]    in_nd,
  ita_out_if.source         dout
);

  localparam int IDXW = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic              busy;
  logic              sign_pend;
  logic [IDXW-1:0]   idx;
  logic [NDW-1:0]    total;
  logic [4*NDIG-1:0] digs;
  logic              is_last;
  logic              take;

  assign is_last  = !sign_pend && (idx == '0);
  assign take     = busy && dout.ready;
  assign in_ready = !busy || (dout.ready && is_last);

  // Output word straight from the serializer registers
  assign dout.valid      = busy;
  assign dout.char_out   = sign_pend ? CH_MINUS : digit_char(digs[4*idx +: 4]);
  assign dout.last       = is_last;
  assign dout.char_count = is_last ? 4'(total) : 4'd0;

  // Control: load a number, then step the sign flag and the digit index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      idx       <= '0;
    end else if (in_ready && in_valid) begin
      busy      <= 1'b1;
      sign_pend <= in_neg;
      idx       <= IDXW'(in_nd - NDW'(1));
    end else if (take) begin
      if (is_last) begin
        busy <= 1'b0;
      end else if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx - IDXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      digs  <= in_digs;
      total <= in_nd + NDW'(in_neg);
    end
  end

  // The sign goes out at most once and before any digit
  a_sign_once: assert property (@(posedge clk) disable iff (rst)
    (take && sign_pend) |=> (busy && !sign_pend && idx == $past(idx)))
    else $error("sign character not followed by the first digit");

  // Digits step down by one per word taken
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (take && !sign_pend && idx != '0) |=> (busy && idx == $past(idx) - IDXW'(1)))
    else $error("digit index did not step down by one");

  // A number is not dropped before its last word is taken
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (busy && !(dout.ready && is_last)) |=> busy)
    else $error("serializer went idle before the last word");

endmodule

// ----- verif/integer_to_ascii_formatter_core_tb.sv -----
// Self-checking testbench for the integer to ASCII formatter core.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_core_tb;
  import ita_pkg::*;

  localparam int          NUM_BITS       = 32;
  localparam int          RANDOM_NUMBERS = 480;
  localparam int          CYCLE_LIMIT    = 300000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          HOLD_CYCLES    = 400;
  localparam logic [7:0]  CH_A_LOWER     = 8'h61;

  // One output word: a character with its end marker and count
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [3:0] count;
  } char_word_t;

  logic clk;
  logic rst;

  ita_in_if #(.VALUE_BITS(NUM_BITS)) in_ch ();
  ita_out_if                         out_ch ();

  integer_to_ascii_formatter_core #(.VALUE_BITS(NUM_BITS)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  char_word_t  pending_chars[$];
  logic [1:0]  row_kind[$];
  logic [31:0] row_value[$];
  string       row_text[$];

  int  numbers_sent;
  int  words_seen;
  int  mismatch_count;
  int  cycle_count;
  logic hold_sink;

  // Expected characters of one number, pushed in output order
  function automatic void predict_number(input logic [1:0] kind, input logic [31:0] value);
    logic [32:0] mag;
    logic        neg;
    logic [7:0]  rev [12];
    int          radix;
    int          nd;
    int          n;
    int          d;
    char_word_t  w;
    neg = (kind == KIND_SDEC) && value[NUM_BITS-1];
    // 33-bit negate so the most negative value keeps its full magnitude
    mag = neg ? (33'd0 - {value[NUM_BITS-1], value}) : {1'b0, value};
    radix = kind[KIND_HEX_BIT] ? 16 : 10;
    nd = 0;
    do begin
      d = int'(mag % radix);
      rev[nd] = (d < 10) ? CH_ZERO + 8'(d) : CH_A_LOWER + 8'(d - 10);
      nd++;
      mag = mag / radix;
    end while (mag != 0);
    n = nd + (neg ? 1 : 0);
    if (neg) begin
      w = '{ch: CH_MINUS, last: 1'b0, count: 4'd0};
      pending_chars.push_back(w);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      w = '{ch: rev[k], last: (k == 0), count: (k == 0) ? 4'(n) : 4'd0};
      pending_chars.push_back(w);
    end
  endfunction

  // Expected characters typed in as text
  function automatic void expect_text(input string txt);
    char_word_t w;
    int         len;
    len = txt.len();
    for (int i = 0; i < len; i++) begin
      w = '{ch: txt[i], last: (i == len - 1), count: (i == len - 1) ? 4'(len) : 4'd0};
      pending_chars.push_back(w);
    end
  endfunction

  // Directed row; empty text means the predictor supplies the result
  function automatic void add_row(input logic [1:0] kind, input logic [31:0] value,
                                  input string txt);
    row_kind.push_back(kind);
    row_value.push_back(value);
    row_text.push_back(txt);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d characters still expected",
             cycle_count, pending_chars.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Long sink stall once the pipeline is busy, so the input backs up
  initial begin
    hold_sink = 1'b0;
    wait (numbers_sent >= 170);
    @(posedge clk);
    hold_sink = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_sink = 1'b0;
  end

  // Character sink: random stalls, check each accepted word
  initial begin
    int         stall;
    logic       taken;
    char_word_t got;
    char_word_t want;
    out_ch.ready = 1'b0;
    words_seen = 0;
    mismatch_count = 0;
    forever begin
      stall = ((words_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        out_ch.ready = !hold_sink;
        @(posedge clk);
        taken = out_ch.ready && out_ch.valid;
      end
      got = '{ch: out_ch.char_out, last: out_ch.last, count: out_ch.char_count};
      words_seen++;
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected word: ch=%h last=%b count=%0d", got.ch, got.last, got.count);
      end else begin
        want = pending_chars.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch on word %0d: expected ch=%h last=%b count=%0d, got ch=%h last=%b count=%0d",
                     words_seen, want.ch, want.last, want.count, got.ch, got.last, got.count);
        end
      end
    end
  end

  // Reset, number source, end of run
  initial begin
    int          gap;
    int          total;
    int          rows;
    logic [1:0]  kind;
    logic [31:0] value;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SDEC;
    in_ch.value = '0;
    numbers_sent = 0;

    // Zero in every kind, extremes, digit rollovers, the unused kind code
    add_row(KIND_SDEC, 32'h0000_0000, "0");
    add_row(KIND_UDEC, 32'h0000_0000, "0");
    add_row(KIND_HEX,  32'h0000_0000, "0");
    add_row(2'd3,      32'h0000_0000, "0");
    add_row(KIND_SDEC, 32'h8000_0000, "-2147483648");
    add_row(KIND_SDEC, 32'h7fff_ffff, "2147483647");
    add_row(KIND_SDEC, 32'hffff_ffff, "-1");
    add_row(KIND_UDEC, 32'hffff_ffff, "4294967295");
    add_row(KIND_UDEC, 32'h8000_0000, "2147483648");
    add_row(KIND_HEX,  32'hffff_ffff, "ffffffff");
    add_row(KIND_HEX,  32'h8000_0000, "80000000");
    add_row(2'd3,      32'hdead_beef, "deadbeef");
    add_row(2'd3,      32'h0000_0007, "7");
    add_row(KIND_SDEC, 32'd9,         "9");
    add_row(KIND_SDEC, 32'd10,        "10");
    add_row(KIND_SDEC, 32'hffff_fff6, "-10");
    add_row(KIND_SDEC, 32'hffff_ff85, "-123");
    add_row(KIND_UDEC, 32'd999999999, "");
    add_row(KIND_UDEC, 32'd1000000000, "1000000000");
    add_row(KIND_HEX,  32'h0000_000f, "f");
    add_row(KIND_HEX,  32'h0000_0010, "10");
    add_row(KIND_HEX,  32'h00a0_b0c0, "a0b0c0");
    add_row(KIND_SDEC, 32'd12345,     "");
    add_row(KIND_UDEC, 32'h1234_abcd, "");

    rows = row_kind.size();
    total = rows + RANDOM_NUMBERS;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int idx = 0; idx < total; idx++) begin
      if (idx < rows) begin
        kind = row_kind[idx];
        value = row_value[idx];
      end else begin
        kind = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
          0: value = $urandom;
          1: value = $urandom >> $urandom_range(0, 31);
          2: value = $urandom_range(0, 20);
          3: value = ~32'($urandom_range(0, 20));
          default: value = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
        endcase
      end
      gap = ((idx / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
      @(negedge clk);
      in_ch.valid = 1'b1;
      in_ch.kind = kind;
      in_ch.value = value;
      do @(posedge clk); while (!in_ch.ready);
      if (idx < rows && row_text[idx] != "")
        expect_text(row_text[idx]);
      else
        predict_number(kind, value);
      numbers_sent++;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    // Wait for every character, then watch for stray words
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers (%0d table rows, the rest random) into %0d characters,",
             numbers_sent, rows, words_seen);
    $display("with random gaps on both sides and one long sink stall; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- integer_to_ascii_formatter_core.f -----
hdl/ita_pkg.sv
hdl/ita_if.sv
hdl/ita_prep.sv
hdl/ita_dabble.sv
hdl/ita_count.sv
hdl/ita_emit.sv
hdl/integer_to_ascii_formatter_core.sv
verif/integer_to_ascii_formatter_core_tb.sv
